// ===== src/elp_pkg.sv =====
// shared types, character codes and helpers for the address/name line parser
`timescale 1ns / 1ps

package elp_pkg;

   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   localparam int unsigned ADDR_OCTETS = 6;
   localparam int unsigned ADDR_W      = 8 * ADDR_OCTETS;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   // result queue depth, must stay a power of two and at least 2
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [6:0] {
      PH_LINE_START  = 7'b0000001,
      PH_SKIP_LINE   = 7'b0000010,
      PH_ADDR_SECOND = 7'b0000100,
      PH_ADDR_SEP    = 7'b0001000,
      PH_ADDR_FIRST  = 7'b0010000,
      PH_NAME_GAP    = 7'b0100000,
      PH_NAME        = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] station_addr;
      logic [7:0]        name_char;
      logic              name_last;
   } rsp_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ===== src/ethers_line_parser.sv =====
// top level: input register, parser step and result queue
// a byte transferred in passes through the input register and the parser step into the result queue
// throughput: one byte per cycle while the result queue has room; an end of stream inside a name gives two results
// and so needs two transfers out, the four-entry result queue absorbs the extra one
// reset: synchronous, active high; parser back at line start with a zero address,
// input register and result queue empty
`timescale 1ns / 1ps

module ethers_line_parser
   import elp_pkg::*;
#(
   parameter int unsigned NAME_LEN = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_stream,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [ADDR_W-1:0] rsp_station_addr,
   output logic [7:0]        rsp_name_char,
   output logic              rsp_name_last
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       room;
   logic       go;
   logic [1:0] res_cnt;
   rsp_type    res0, res1, rsp_data;

   assign go        = in_valid_ff && room;
   assign req_ready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   elp_step #(
      .NAME_LEN(NAME_LEN)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .go            (go),
      .in_byte       (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .res_cnt       (res_cnt),
      .res0          (res0),
      .res1          (res1)
   );

   elp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (res_cnt),
      .push_d0   (res0),
      .push_d1   (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_station_addr = rsp_data.station_addr;
   assign rsp_name_char    = rsp_data.name_char;
   assign rsp_name_last    = rsp_data.name_last;

endmodule

// ===== src/elp_step.sv =====
// parser state and the per-byte transition, up to two results per byte
`timescale 1ns / 1ps

module elp_step
   import elp_pkg::*;
#(
   parameter int unsigned NAME_LEN = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic [7:0] in_byte,
   input  logic       end_of_stream,
   output logic [1:0] res_cnt,
   output rsp_type    res0,
   output rsp_type    res1
);

   localparam int unsigned CntW = (NAME_LEN > 2) ? $clog2(NAME_LEN) : 1;
   localparam logic [CntW-1:0] CntLimit = CntW'(NAME_LEN - 1);

   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [2:0]        octet_ff, octet_in;
   logic [3:0]        first_ff, first_in;
   logic [7:0]        held_ff, held_in;
   logic              held_valid_ff, held_valid_in;
   logic [CntW-1:0]   count_ff, count_in;

   logic [4:0] hex;
   logic       blank;
   rsp_type    char_rsp;

   function automatic logic [ADDR_W-1:0] put_octet(input logic [ADDR_W-1:0] a,
                                                   input logic [2:0] idx,
                                                   input logic [7:0] v);
      logic [ADDR_W-1:0] r;
      r = a;
      case (idx)
         3'd0: r[47:40] = v;
         3'd1: r[39:32] = v;
         3'd2: r[31:24] = v;
         3'd3: r[23:16] = v;
         3'd4: r[15:8]  = v;
         3'd5: r[7:0]   = v;
         default: r = a;
      endcase
      return r;
   endfunction

   assign hex   = hex_digit(in_byte);
   assign blank = is_blank(in_byte);

   always_comb begin
      phase_in      = phase_ff;
      addr_in       = addr_ff;
      octet_in      = octet_ff;
      first_in      = first_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      res_cnt       = 2'd0;
      char_rsp      = '{kind: KIND_CHAR, station_addr: addr_ff, name_char: held_ff,
                        name_last: 1'b1};
      res0          = char_rsp;
      res1          = char_rsp;

      if (end_of_stream) begin
         if (phase_ff == PH_ADDR_SECOND) begin
            addr_in = put_octet(addr_ff, octet_ff, {4'h0, first_ff});
         end
         if (phase_ff == PH_NAME && held_valid_ff) begin
            res0    = char_rsp;
            res1    = '{kind: KIND_EOS, station_addr: addr_in, name_char: 8'h00,
                        name_last: 1'b0};
            res_cnt = 2'd2;
         end else begin
            res0    = '{kind: KIND_EOS, station_addr: addr_in, name_char: 8'h00,
                        name_last: 1'b0};
            res_cnt = 2'd1;
         end
         phase_in      = PH_LINE_START;
         held_valid_in = 1'b0;
         count_in      = '0;
      end else begin
         case (phase_ff)
            PH_SKIP_LINE: begin
               if (in_byte == CH_NEWLINE) phase_in = PH_LINE_START;
            end
            PH_ADDR_SECOND: begin
               if (hex[4]) begin
                  addr_in  = put_octet(addr_ff, octet_ff, {first_ff, hex[3:0]});
                  phase_in = PH_ADDR_SEP;
               end else begin
                  addr_in = put_octet(addr_ff, octet_ff, {4'h0, first_ff});
                  if (in_byte == CH_COLON) begin
                     if (octet_ff >= 3'd5) begin
                        phase_in = PH_NAME_GAP;
                     end else begin
                        octet_in = octet_ff + 3'd1;
                        phase_in = PH_ADDR_FIRST;
                     end
                  end else begin
                     phase_in = (in_byte == CH_NEWLINE) ? PH_LINE_START : PH_NAME_GAP;
                  end
               end
            end
            PH_ADDR_SEP: begin
               if (in_byte == CH_COLON) begin
                  if (octet_ff >= 3'd5) begin
                     phase_in = PH_NAME_GAP;
                  end else begin
                     octet_in = octet_ff + 3'd1;
                     phase_in = PH_ADDR_FIRST;
                  end
               end else begin
                  phase_in = (in_byte == CH_NEWLINE) ? PH_LINE_START : PH_NAME_GAP;
               end
            end
            PH_ADDR_FIRST: begin
               if (hex[4]) begin
                  first_in = hex[3:0];
                  phase_in = PH_ADDR_SECOND;
               end else begin
                  phase_in = (in_byte == CH_NEWLINE) ? PH_LINE_START : PH_NAME_GAP;
               end
            end
            PH_NAME_GAP: begin
               if (in_byte == CH_NEWLINE) begin
                  phase_in = PH_LINE_START;
               end else if (blank) begin
                  phase_in = PH_NAME_GAP;
               end else if (in_byte == CH_HASH) begin
                  phase_in = PH_SKIP_LINE;
               end else begin
                  held_in       = in_byte;
                  held_valid_in = 1'b1;
                  count_in      = CntW'(1);
                  phase_in      = PH_NAME;
               end
            end
            PH_NAME: begin
               if (!held_valid_ff) begin
                  phase_in = PH_NAME_GAP;
               end else if (blank) begin
                  res_cnt       = 2'd1;
                  held_valid_in = 1'b0;
                  phase_in      = (in_byte == CH_NEWLINE) ? PH_LINE_START : PH_NAME_GAP;
               end else if (count_ff >= CntLimit) begin
                  // name full: flush it and drop this byte
                  res_cnt       = 2'd1;
                  held_valid_in = 1'b0;
                  phase_in      = PH_NAME_GAP;
               end else begin
                  res0.name_last = 1'b0;
                  res_cnt        = 2'd1;
                  held_in        = in_byte;
                  count_in       = count_ff + CntW'(1);
               end
            end
            default: begin
               // line start, and any code that is not a valid phase
               if (blank) begin
                  phase_in = PH_LINE_START;
               end else if (hex[4]) begin
                  first_in = hex[3:0];
                  octet_in = 3'd0;
                  phase_in = PH_ADDR_SECOND;
               end else begin
                  phase_in = PH_SKIP_LINE;
               end
            end
         endcase
      end

      if (!go) begin
         res_cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LINE_START;
         addr_ff       <= '0;
         octet_ff      <= 3'd0;
         first_ff      <= 4'h0;
         held_ff       <= 8'h00;
         held_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else if (go) begin
         phase_ff      <= phase_in;
         addr_ff       <= addr_in;
         octet_ff      <= octet_in;
         first_ff      <= first_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         count_ff      <= count_in;
      end
   end

   a_held_in_name: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (phase_ff == PH_NAME))
      else $error("held name character outside of a name");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntLimit)
      else $error("name length count past limit");

   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      (go && end_of_stream) |=> (phase_ff == PH_LINE_START) && !held_valid_ff)
      else $error("parser not back at line start after end of stream");

endmodule

// ===== src/elp_rsp_fifo.sv =====
// small result queue, takes up to two results per cycle and hands out one
`timescale 1ns / 1ps

module elp_rsp_fifo
   import elp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] push_cnt,
   input  rsp_type    push_d0,
   input  rsp_type    push_d1,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   rsp_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   pop;
   logic [QUEUE_PTR_W-1:0] wr_next;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   // two free entries needed, a byte can cause two results
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign wr_next   = wr_ff + QUEUE_PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + QUEUE_PTR_W'(push_cnt);
      rd_in    = pop ? rd_ff + QUEUE_PTR_W'(1) : rd_ff;
      count_in = count_ff + QUEUE_CNT_W'(push_cnt) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) mem_ff[wr_ff] <= push_d0;
      if (push_cnt == 2'd2) mem_ff[wr_next] <= push_d1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue count past depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room)
      else $error("result pushed without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push_cnt == 2'd0) |=> (count_ff == $past(count_ff) - QUEUE_CNT_W'(1)))
      else $error("result queue count wrong after a transfer out");

endmodule

// ===== tb/sv/ethers_line_parser_tb.sv =====
// testbench for the address/name line parser: directed table, then random text lines
`timescale 1ns / 1ps

module ethers_line_parser_tb
   import elp_pkg::*;
();

   localparam int NAME_LEN     = 128;
   localparam int CLK_PERIOD   = 10;
   localparam int ITEM_TOTAL   = 1450;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DIR_ROWS     = 28;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } stim_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
      logic       typed;
      rsp_type    want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_in_byte = 8'h00;
   logic              req_end_of_stream = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_kind;
   logic [ADDR_W-1:0] rsp_station_addr;
   logic [7:0]        rsp_name_char;
   logic              rsp_name_last;

   // parser state as predicted from the bytes transferred so far
   phase_type         ps_phase;
   logic [ADDR_W-1:0] ps_addr;
   logic [2:0]        ps_octet;
   logic [3:0]        ps_hi_nibble;
   logic [7:0]        ps_pend_char;
   logic              ps_pend_valid;
   logic [7:0]        ps_name_len;

   rsp_type     parsed_rsp_q[$];
   rsp_type     step_rsp_q[$];
   stim_type    line_q[$];
   dir_row_type dir_table [DIR_ROWS];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int items_sent = 0;
   int err_count = 0;
   int cycle_count = 0;

   ethers_line_parser #(.NAME_LEN(NAME_LEN)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_station_addr  (rsp_station_addr),
      .rsp_name_char     (rsp_name_char),
      .rsp_name_last     (rsp_name_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   function automatic logic space_char(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      err_count++;
   endtask

   task automatic emit_rsp(input logic kind, input logic [7:0] c, input logic last);
      step_rsp_q.push_back('{kind, ps_addr, c, last});
   endtask

   task automatic store_octet(input logic [7:0] v);
      if (ps_octet <= 3'd5) begin
         ps_addr[8 * (5 - ps_octet) +: 8] = v;
      end
   endtask

   // ':' after an octet; after the sixth it ends the address
   task automatic next_octet();
      if (ps_octet >= 3'd5) begin
         ps_phase = PH_NAME_GAP;
      end else begin
         ps_octet++;
         ps_phase = PH_ADDR_FIRST;
      end
   endtask

   task automatic end_addr(input logic [7:0] c);
      ps_phase = (c == CH_NEWLINE) ? PH_LINE_START : PH_NAME_GAP;
   endtask

   task automatic parse_step(input logic [7:0] c, input logic eos);
      int hv;
      hv = hex_value(c);
      if (eos) begin
         if (ps_phase == PH_NAME && ps_pend_valid) emit_rsp(KIND_CHAR, ps_pend_char, 1'b1);
         if (ps_phase == PH_ADDR_SECOND) store_octet({4'h0, ps_hi_nibble});
         emit_rsp(KIND_EOS, 8'h00, 1'b0);
         ps_phase = PH_LINE_START;
         ps_pend_valid = 1'b0;
         ps_name_len = 8'd0;
         return;
      end
      case (ps_phase)
         PH_SKIP_LINE: begin
            if (c == CH_NEWLINE) ps_phase = PH_LINE_START;
         end
         PH_ADDR_SECOND: begin
            if (hv >= 0) begin
               store_octet({ps_hi_nibble, 4'(hv)});
               ps_phase = PH_ADDR_SEP;
            end else begin
               store_octet({4'h0, ps_hi_nibble});
               if (c == CH_COLON) next_octet();
               else end_addr(c);
            end
         end
         PH_ADDR_SEP: begin
            if (c == CH_COLON) next_octet();
            else end_addr(c);
         end
         PH_ADDR_FIRST: begin
            if (hv >= 0) begin
               ps_hi_nibble = 4'(hv);
               ps_phase = PH_ADDR_SECOND;
            end else begin
               end_addr(c);
            end
         end
         PH_NAME_GAP: begin
            if (c == CH_NEWLINE) begin
               ps_phase = PH_LINE_START;
            end else if (c == CH_HASH) begin
               ps_phase = PH_SKIP_LINE;
            end else if (!space_char(c)) begin
               ps_pend_char = c;
               ps_pend_valid = 1'b1;
               ps_name_len = 8'd1;
               ps_phase = PH_NAME;
            end
         end
         PH_NAME: begin
            if (!ps_pend_valid) begin
               ps_phase = PH_NAME_GAP;
            end else if (space_char(c)) begin
               emit_rsp(KIND_CHAR, ps_pend_char, 1'b1);
               ps_pend_valid = 1'b0;
               ps_phase = (c == CH_NEWLINE) ? PH_LINE_START : PH_NAME_GAP;
            end else if (int'(ps_name_len) >= NAME_LEN - 1) begin
               // name full: close it and drop this character
               emit_rsp(KIND_CHAR, ps_pend_char, 1'b1);
               ps_pend_valid = 1'b0;
               ps_phase = PH_NAME_GAP;
            end else begin
               emit_rsp(KIND_CHAR, ps_pend_char, 1'b0);
               ps_pend_char = c;
               ps_name_len = ps_name_len + 8'd1;
            end
         end
         default: begin
            if (space_char(c)) begin
               ps_phase = PH_LINE_START;
            end else if (hv >= 0) begin
               ps_hi_nibble = 4'(hv);
               ps_octet = 3'd0;
               ps_phase = PH_ADDR_SECOND;
            end else begin
               ps_phase = PH_SKIP_LINE;
            end
         end
      endcase
   endtask

   task automatic send_item(input logic [7:0] ch, input logic eos, input logic typed,
                            input rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= ch;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      parse_step(ch, eos);
      if (typed) parsed_rsp_q.push_back(want);
      else foreach (step_rsp_q[i]) parsed_rsp_q.push_back(step_rsp_q[i]);
      step_rsp_q.delete();
   endtask

   task automatic push_ch(input logic [7:0] c);
      line_q.push_back('{c, 1'b0});
   endtask

   // blank other than newline
   function automatic logic [7:0] sep_char();
      int k;
      k = $urandom_range(0, 4);
      if (k == 0) return CH_SPACE;
      if (k == 1) return CH_TAB;
      return 8'(int'(CH_NEWLINE) + k - 1);
   endfunction

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'(int'("0") + v);
      return 8'(($urandom_range(0, 1) ? int'("a") : int'("A")) + v - 10);
   endfunction

   function automatic logic [7:0] name_char_rand();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (space_char(c));
      return c;
   endfunction

   // one text line: mostly address plus names, some junk, some cut short by end of stream
   task automatic build_line();
      int n_oct;
      int n_names;
      int len;
      int cut;
      int sel;
      line_q.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(0, 10)) push_ch(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) push_ch(sep_char());
         n_oct = $urandom_range(1, 7);
         for (int k = 0; k < n_oct; k++) begin
            if (k > 0) push_ch(CH_COLON);
            if (k == 0 || $urandom_range(0, 15) != 0) begin
               push_ch(hex_char($urandom_range(0, 15)));
               if ($urandom_range(0, 2) != 0) push_ch(hex_char($urandom_range(0, 15)));
            end
         end
         sel = $urandom_range(0, 9);
         n_names = 0;
         if (sel != 0) begin
            push_ch(sel == 1 ? 8'($urandom_range(0, 255)) : sep_char());
            n_names = $urandom_range(0, 3);
         end
         for (int j = 0; j < n_names; j++) begin
            if ($urandom_range(0, 9) == 0) begin
               push_ch(CH_HASH);
               repeat ($urandom_range(0, 6)) push_ch(name_char_rand());
               break;
            end
            if ($urandom_range(0, 24) == 0) begin
               // around the cut length, or long enough to be cut twice
               len = $urandom_range(0, 1) ? NAME_LEN - 3 + $urandom_range(0, 4)
                                          : 2 * NAME_LEN + $urandom_range(0, 3);
            end else begin
               len = $urandom_range(1, 10);
            end
            repeat (len) push_ch(name_char_rand());
            if (j < n_names - 1) repeat ($urandom_range(1, 2)) push_ch(sep_char());
         end
      end
      push_ch(CH_NEWLINE);
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(0, line_q.size());
         while (line_q.size() > cut) void'(line_q.pop_back());
         line_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_station_addr, rsp_name_char, rsp_name_last};
         if (parsed_rsp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer kind %0d addr %h char %h last %0d",
                                      got.kind, got.station_addr, got.name_char, got.name_last));
         end else begin
            want = parsed_rsp_q.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.station_addr !== want.station_addr)
               report_mismatch($sformatf("station_addr %h, want %h",
                                         got.station_addr, want.station_addr));
            if (got.name_char !== want.name_char)
               report_mismatch($sformatf("name_char %h, want %h", got.name_char, want.name_char));
            if (got.name_last !== want.name_last)
               report_mismatch($sformatf("name_last %0d, want %0d", got.name_last, want.name_last));
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL ethers_line_parser");
      $finish;
   end

   initial begin
      // ff:00:aa from "Ff:0:aA", single digit octets, skipped lines, end of stream cases
      dir_table = '{
         '{8'h00, 1'b1, 1'b1, '{KIND_EOS, 48'h0, 8'h00, 1'b0}},
         '{"F", 1'b0, 1'b0, '0},
         '{"f", 1'b0, 1'b0, '0},
         '{CH_COLON, 1'b0, 1'b0, '0},
         '{"0", 1'b0, 1'b0, '0},
         '{CH_COLON, 1'b0, 1'b0, '0},
         '{"a", 1'b0, 1'b0, '0},
         '{"A", 1'b0, 1'b0, '0},
         '{CH_SPACE, 1'b0, 1'b0, '0},
         '{"z", 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b1, '{KIND_CHAR, 48'hff00_aa00_0000, "z", 1'b0}},
         '{CH_NEWLINE, 1'b0, 1'b1, '{KIND_CHAR, 48'hff00_aa00_0000, 8'hFF, 1'b1}},
         '{8'h00, 1'b0, 1'b0, '0},
         '{CH_NEWLINE, 1'b0, 1'b0, '0},
         '{"3", 1'b0, 1'b0, '0},
         '{8'hFF, 1'b1, 1'b1, '{KIND_EOS, 48'h0300_aa00_0000, 8'h00, 1'b0}},
         '{"9", 1'b0, 1'b0, '0},
         '{"g", 1'b0, 1'b0, '0},
         '{CH_HASH, 1'b0, 1'b0, '0},
         '{CH_NEWLINE, 1'b0, 1'b0, '0},
         '{"2", 1'b0, 1'b0, '0},
         '{"b", 1'b0, 1'b0, '0},
         '{"q", 1'b0, 1'b0, '0},
         '{"x", 1'b0, 1'b0, '0},
         '{8'h00, 1'b1, 1'b0, '0},
         '{"5", 1'b0, 1'b0, '0},
         '{CH_COLON, 1'b0, 1'b0, '0},
         '{CH_NEWLINE, 1'b0, 1'b0, '0}
      };
      ps_phase = PH_LINE_START;
      ps_addr = '0;
      ps_octet = 3'd0;
      ps_hi_nibble = 4'h0;
      ps_pend_char = 8'h00;
      ps_pend_valid = 1'b0;
      ps_name_len = 8'd0;
      send_idle_pct = 26;
      rsp_idle_pct = 82;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_item(dir_table[i].ch, dir_table[i].eos, dir_table[i].typed, dir_table[i].want);
      end

      while (items_sent < ITEM_TOTAL) begin
         if (items_sent >= 2 * ITEM_TOTAL / 3) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (items_sent >= ITEM_TOTAL / 3) begin
            send_idle_pct = 82;
            rsp_idle_pct = 26;
         end
         build_line();
         foreach (line_q[i]) send_item(line_q[i].ch, line_q[i].eos, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (parsed_rsp_q.size() != 0) @(posedge clock);
      // a late stray transfer would still show up here
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) $display("PASS ethers_line_parser");
      else $display("FAIL ethers_line_parser");
      $finish;
   end

endmodule
